[src/rctbf_pkg.sv]
// Shared constants, register codes and datapath helpers for the transmitter tick unit.
package rctbf_pkg;

  // Channel and register field widths.
  localparam int unsigned StickW = 12;
  localparam int unsigned ChanW  = 11;
  localparam int unsigned LevelW = 12;
  localparam int unsigned CountW = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Pulse values sent on the radio channels.
  localparam logic [ChanW-1:0] PulseMin = 11'd1000;
  localparam logic [ChanW-1:0] PulseMax = 11'd2000;

  // Register reset values.
  localparam logic [LevelW-1:0] FloorLevelRst    = 12'd2057;
  localparam logic [LevelW-1:0] LowLevelRst      = 12'd2308;
  localparam logic [LevelW-1:0] CriticalLevelRst = 12'd2245;
  localparam logic [CountW-1:0] SagLimitRst      = 8'd100;
  localparam logic [CountW-1:0] RecoveryLimitRst = 8'd50;
  localparam logic [MsW-1:0]    FailsafeMsRst    = 16'd500;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FLOOR_LEVEL    = 3'd0,
    REG_LOW_LEVEL      = 3'd1,
    REG_CRITICAL_LEVEL = 3'd2,
    REG_SAG_LIMIT      = 3'd3,
    REG_RECOVERY_LIMIT = 3'd4,
    REG_FAILSAFE_MS    = 3'd5
  } cfg_reg_e;

  // Scale a 12-bit stick sample to 1000 + floor(raw * 1000 / 4095).
  // The quotient is estimated with the 1/4096 series and corrected once.
  function automatic logic [ChanW-1:0] scale_stick(input logic [StickW-1:0] raw);
    logic [21:0] prod;
    logic [21:0] sum;
    logic [9:0]  q_est;
    logic [21:0] back;
    logic [21:0] rem;
    logic [9:0]  q;
    prod  = ({10'd0, raw} << 10) - ({10'd0, raw} << 4) - ({10'd0, raw} << 3);
    sum   = prod + (prod >> 12);
    q_est = sum[21:12];
    back  = {q_est, 12'd0} - {12'd0, q_est};
    rem   = prod - back;
    q     = (rem >= 22'd4095) ? q_est + 10'd1 : q_est;
    return PulseMin + {1'b0, q};
  endfunction

  // True while (now mod 500) < 250, the on half of the buzzer cadence.
  // The residue is folded with 2^8k mod 500 and 512 mod 500 = 12.
  function automatic logic buzz_phase(input logic [TimeW-1:0] now);
    logic [16:0] s;
    logic [11:0] t;
    logic [9:0]  u;
    logic [9:0]  m;
    s = 17'(now[7:0]) + (17'(now[15:8]) << 8) + 17'(now[23:16]) * 17'd36
        + 17'(now[31:24]) * 17'd216;
    t = 12'(s[8:0]) + 12'(s[16:9]) * 12'd12;
    u = 10'(t[8:0]) + 10'(t[11:9]) * 10'd12;
    m = (u >= 10'd500) ? u - 10'd500 : u;
    return (m < 10'd250);
  endfunction

endpackage

[src/rc_transmitter_battery_failsafe_unit.sv]
// Top level of the transmitter control tick unit with battery guard and link failsafe.
//
// One input word is one control tick: four stick samples, the arm and aux switches,
// the radio link result, an optional battery reading and a millisecond timestamp.
// One output word comes back per tick with the scaled channels, the arm and disarm
// bits and the lamp, buzzer and failsafe indications.
// Input and output channels use valid/ready; a word moves when both are high.
// Configuration writes use cfg_valid_i/cfg_ready_o with a register index and data;
// cfg_ready_o is always high and unknown indexes are dropped. Write only while idle.
// Each word passes the input register and then the output register. The stick scaling
// and the buzzer phase are formed ahead of the input register; the battery and link
// state update sits between the input register and the output register.
// Throughput: one word per cycle, sustained while the receiver keeps out_ready_i high.
// A stalled receiver holds the output register; one more word waits in the input
// register, and in_ready_o drops only when both are full.
// Reset clears all tick state, empties both registers and reloads the register
// defaults.
module rc_transmitter_battery_failsafe_unit
  import rctbf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [StickW-1:0]   throttle_raw_i,
  input  logic [StickW-1:0]   roll_raw_i,
  input  logic [StickW-1:0]   pitch_raw_i,
  input  logic [StickW-1:0]   yaw_raw_i,
  input  logic                arm_switch_i,
  input  logic                aux_switch_i,
  input  logic                link_ok_i,
  input  logic                telem_valid_i,
  input  logic [LevelW-1:0]   voltage_raw_i,
  input  logic [TimeW-1:0]    now_ms_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ChanW-1:0]    throttle_out_o,
  output logic [ChanW-1:0]    roll_out_o,
  output logic [ChanW-1:0]    pitch_out_o,
  output logic [ChanW-1:0]    yaw_out_o,
  output logic [ChanW-1:0]    aux_out_o,
  output logic                arm_cmd_o,
  output logic                disarm_cmd_o,
  output logic                arm_lamp_o,
  output logic                low_batt_lamp_o,
  output logic                buzzer_on_o,
  output logic                failsafe_flag_o
);

  // Configuration registers.
  logic [LevelW-1:0] floor_level_q, low_level_q, critical_level_q;
  logic [CountW-1:0] sag_limit_q, recovery_limit_q;
  logic [MsW-1:0]    failsafe_ms_q;

  // Input register.
  logic              in_valid_q;
  logic [ChanW-1:0]  thr_q, roll_q, pitch_q, yaw_q;
  logic              arm_q, aux_q, link_q, telem_q, phase_q;
  logic [LevelW-1:0] volt_q;
  logic [TimeW-1:0]  now_q;

  // Tick state.
  logic [TimeW-1:0]  last_good_q, last_good_d;
  logic              link_lost_q, link_lost_d;
  logic [CountW-1:0] low_cnt_q, low_cnt_d;
  logic [CountW-1:0] crit_cnt_q, crit_cnt_d;
  logic [CountW-1:0] good_cnt_q, good_cnt_d;
  logic              low_flag_q, low_flag_d;
  logic              crit_flag_q, crit_flag_d;
  logic              stop_q, stop_d;

  // Output register.
  logic              out_valid_q;
  logic [ChanW-1:0]  thr_out_q, roll_out_q, pitch_out_q, yaw_out_q, aux_out_q;
  logic              arm_cmd_q, disarm_cmd_q, arm_lamp_q, low_lamp_q, buzz_q, fs_q;

  logic              advance;
  logic              in_fire;
  logic              forced;
  logic [TimeW-1:0]  silence;
  logic              buzz_d;

  // Handshake: the state stage moves when the output register is free or drains.
  assign advance     = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_level_q    <= FloorLevelRst;
      low_level_q      <= LowLevelRst;
      critical_level_q <= CriticalLevelRst;
      sag_limit_q      <= SagLimitRst;
      recovery_limit_q <= RecoveryLimitRst;
      failsafe_ms_q    <= FailsafeMsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FLOOR_LEVEL:    floor_level_q    <= cfg_data_i[LevelW-1:0];
        REG_LOW_LEVEL:      low_level_q      <= cfg_data_i[LevelW-1:0];
        REG_CRITICAL_LEVEL: critical_level_q <= cfg_data_i[LevelW-1:0];
        REG_SAG_LIMIT:      sag_limit_q      <= cfg_data_i[CountW-1:0];
        REG_RECOVERY_LIMIT: recovery_limit_q <= cfg_data_i[CountW-1:0];
        REG_FAILSAFE_MS:    failsafe_ms_q    <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload, with sticks already scaled and the buzzer phase decoded.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      thr_q   <= scale_stick(throttle_raw_i);
      roll_q  <= scale_stick(roll_raw_i);
      pitch_q <= PulseMin + PulseMax - scale_stick(pitch_raw_i);
      yaw_q   <= scale_stick(yaw_raw_i);
      arm_q   <= arm_switch_i;
      aux_q   <= aux_switch_i;
      link_q  <= link_ok_i;
      telem_q <= telem_valid_i;
      volt_q  <= voltage_raw_i;
      now_q   <= now_ms_i;
      phase_q <= buzz_phase(now_ms_i);
    end
  end

  // Tick state update: stop latch, link and battery tracking, then the timeout.
  always_comb begin
    forced      = crit_flag_q | (arm_q & stop_q);
    stop_d      = forced;
    last_good_d = last_good_q;
    link_lost_d = link_lost_q;
    low_cnt_d   = low_cnt_q;
    crit_cnt_d  = crit_cnt_q;
    good_cnt_d  = good_cnt_q;
    low_flag_d  = low_flag_q;
    crit_flag_d = crit_flag_q;

    if (link_q) begin
      last_good_d = now_q;
      link_lost_d = 1'b0;
      if (telem_q) begin
        if (volt_q > floor_level_q) begin
          // Low battery sag and recovery.
          if (volt_q < low_level_q) begin
            low_cnt_d  = (low_cnt_q == '1) ? low_cnt_q : low_cnt_q + 8'd1;
            good_cnt_d = '0;
            if (low_cnt_d >= sag_limit_q) begin
              low_flag_d = 1'b1;
            end
          end else begin
            low_cnt_d  = '0;
            good_cnt_d = (good_cnt_q == '1) ? good_cnt_q : good_cnt_q + 8'd1;
            if (good_cnt_d >= recovery_limit_q) begin
              low_flag_d = 1'b0;
            end
          end
          // Critical sag; it clears on the same recovery count.
          if (volt_q < critical_level_q) begin
            crit_cnt_d = (crit_cnt_q == '1) ? crit_cnt_q : crit_cnt_q + 8'd1;
            if (crit_cnt_d >= sag_limit_q) begin
              crit_flag_d = 1'b1;
            end
          end else begin
            crit_cnt_d = '0;
            if (good_cnt_d >= recovery_limit_q) begin
              crit_flag_d = 1'b0;
            end
          end
        end else begin
          // A reading at or below the floor is treated as low at once.
          low_flag_d = 1'b1;
        end
      end
    end

    // Link timeout drops all battery state.
    silence = now_q - last_good_d;
    if (silence > {{(TimeW-MsW){1'b0}}, failsafe_ms_q}) begin
      link_lost_d = 1'b1;
      low_flag_d  = 1'b0;
      crit_flag_d = 1'b0;
      low_cnt_d   = '0;
      crit_cnt_d  = '0;
      good_cnt_d  = '0;
    end

    buzz_d = crit_flag_d & arm_q & ~link_lost_d & phase_q;
  end

  // Tick state registers, updated as each word passes through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_good_q <= '0;
      link_lost_q <= 1'b0;
      low_cnt_q   <= '0;
      crit_cnt_q  <= '0;
      good_cnt_q  <= '0;
      low_flag_q  <= 1'b0;
      crit_flag_q <= 1'b0;
      stop_q      <= 1'b0;
    end else if (advance) begin
      last_good_q <= last_good_d;
      link_lost_q <= link_lost_d;
      low_cnt_q   <= low_cnt_d;
      crit_cnt_q  <= crit_cnt_d;
      good_cnt_q  <= good_cnt_d;
      low_flag_q  <= low_flag_d;
      crit_flag_q <= crit_flag_d;
      stop_q      <= stop_d;
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      thr_out_q    <= forced ? PulseMin : thr_q;
      roll_out_q   <= roll_q;
      pitch_out_q  <= pitch_q;
      yaw_out_q    <= yaw_q;
      aux_out_q    <= aux_q ? PulseMax : PulseMin;
      arm_cmd_q    <= ~forced & arm_q;
      disarm_cmd_q <= forced | ~arm_q;
      arm_lamp_q   <= ~forced & arm_q;
      low_lamp_q   <= low_flag_d;
      buzz_q       <= buzz_d;
      fs_q         <= link_lost_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign throttle_out_o  = thr_out_q;
  assign roll_out_o      = roll_out_q;
  assign pitch_out_o     = pitch_out_q;
  assign yaw_out_o       = yaw_out_q;
  assign aux_out_o       = aux_out_q;
  assign arm_cmd_o       = arm_cmd_q;
  assign disarm_cmd_o    = disarm_cmd_q;
  assign arm_lamp_o      = arm_lamp_q;
  assign low_batt_lamp_o = low_lamp_q;
  assign buzzer_on_o     = buzz_q;
  assign failsafe_flag_o = fs_q;

endmodule

[test/testbench.sv]
// Self-checking testbench for the transmitter control tick unit.
module testbench;
  import rctbf_pkg::*;

  // Scaling and buzzer cadence constants of the tick.
  localparam int unsigned StickFull   = 4095;
  localparam int unsigned PulseSpan   = 1000;
  localparam int unsigned PitchMirror = 3000;
  localparam int unsigned BuzzPeriod  = 500;
  localparam int unsigned BuzzOn      = 250;

  // Register indexes that the block must ignore.
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  typedef struct packed {
    logic [StickW-1:0] throttle;
    logic [StickW-1:0] roll;
    logic [StickW-1:0] pitch;
    logic [StickW-1:0] yaw;
    logic              arm;
    logic              aux;
    logic              link_ok;
    logic              telem;
    logic [LevelW-1:0] volt;
    logic [TimeW-1:0]  now;
  } tick_t;

  typedef struct packed {
    logic [ChanW-1:0] throttle;
    logic [ChanW-1:0] roll;
    logic [ChanW-1:0] pitch;
    logic [ChanW-1:0] yaw;
    logic [ChanW-1:0] aux;
    logic             arm_cmd;
    logic             disarm_cmd;
    logic             arm_lamp;
    logic             low_lamp;
    logic             buzzer;
    logic             failsafe;
  } pulse_word_t;

  typedef enum int {BATT_GOOD, BATT_LOW, BATT_CRIT, BATT_FLOOR, BATT_ANY} batt_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [StickW-1:0]   throttle_raw_i = '0;
  logic [StickW-1:0]   roll_raw_i = '0;
  logic [StickW-1:0]   pitch_raw_i = '0;
  logic [StickW-1:0]   yaw_raw_i = '0;
  logic                arm_switch_i = 1'b0;
  logic                aux_switch_i = 1'b0;
  logic                link_ok_i = 1'b0;
  logic                telem_valid_i = 1'b0;
  logic [LevelW-1:0]   voltage_raw_i = '0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ChanW-1:0]    throttle_out_o;
  logic [ChanW-1:0]    roll_out_o;
  logic [ChanW-1:0]    pitch_out_o;
  logic [ChanW-1:0]    yaw_out_o;
  logic [ChanW-1:0]    aux_out_o;
  logic                arm_cmd_o;
  logic                disarm_cmd_o;
  logic                arm_lamp_o;
  logic                low_batt_lamp_o;
  logic                buzzer_on_o;
  logic                failsafe_flag_o;

  // Predicted configuration and tick state.
  logic [LevelW-1:0] lvl_floor, lvl_low, lvl_crit;
  logic [CountW-1:0] sag_lim, rec_lim;
  logic [MsW-1:0]    fs_ms;
  logic [TimeW-1:0]  last_link_ms;
  logic              link_down;
  logic [CountW-1:0] low_sags, crit_sags, good_ticks;
  logic              low_batt, crit_batt, stop_held;

  // Scoreboard and stimulus state.
  pulse_word_t pending_words[$];
  int          errors = 0;
  bit          no_gaps = 1'b0;
  bit          steady_link = 1'b0;
  logic [TimeW-1:0] sim_now = 32'd2000;
  int          outage_left = 0;
  batt_mode_e  batt_mode = BATT_GOOD;
  int          batt_left = 0;
  logic        arm_state = 1'b1;

  rc_transmitter_battery_failsafe_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .throttle_raw_i, .roll_raw_i, .pitch_raw_i, .yaw_raw_i,
    .arm_switch_i, .aux_switch_i, .link_ok_i, .telem_valid_i,
    .voltage_raw_i, .now_ms_i,
    .out_valid_o, .out_ready_i,
    .throttle_out_o, .roll_out_o, .pitch_out_o, .yaw_out_o, .aux_out_o,
    .arm_cmd_o, .disarm_cmd_o, .arm_lamp_o, .low_batt_lamp_o,
    .buzzer_on_o, .failsafe_flag_o
  );

  initial forever #10 clk_i = ~clk_i;

  // Run limit, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("rc_transmitter_battery_failsafe_unit regression: fail");
    $finish;
  end

  // Idle length shared by both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ChanW-1:0] stick_pulse(input logic [StickW-1:0] raw);
    int unsigned wide;
    wide = raw;
    wide = PulseSpan + (wide * PulseSpan) / StickFull;
    return wide[ChanW-1:0];
  endfunction

  function automatic logic [CountW-1:0] count_up(input logic [CountW-1:0] c);
    return (c == 8'd255) ? c : c + 8'd1;
  endfunction

  function automatic void clear_predictor();
    lvl_floor    = FloorLevelRst;
    lvl_low      = LowLevelRst;
    lvl_crit     = CriticalLevelRst;
    sag_lim      = SagLimitRst;
    rec_lim      = RecoveryLimitRst;
    fs_ms        = FailsafeMsRst;
    last_link_ms = '0;
    link_down    = 1'b0;
    low_sags     = '0;
    crit_sags    = '0;
    good_ticks   = '0;
    low_batt     = 1'b0;
    crit_batt    = 1'b0;
    stop_held    = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    unique case (idx)
      REG_FLOOR_LEVEL:    lvl_floor = data[LevelW-1:0];
      REG_LOW_LEVEL:      lvl_low   = data[LevelW-1:0];
      REG_CRITICAL_LEVEL: lvl_crit  = data[LevelW-1:0];
      REG_SAG_LIMIT:      sag_lim   = data[CountW-1:0];
      REG_RECOVERY_LIMIT: rec_lim   = data[CountW-1:0];
      REG_FAILSAFE_MS:    fs_ms     = data[MsW-1:0];
      default: ;
    endcase
  endfunction

  // Sag and recovery counting for one battery reading.
  function automatic void apply_reading(input logic [LevelW-1:0] v);
    if (v > lvl_floor) begin
      if (v < lvl_low) begin
        low_sags   = count_up(low_sags);
        good_ticks = '0;
        if (low_sags >= sag_lim) low_batt = 1'b1;
      end else begin
        low_sags   = '0;
        good_ticks = count_up(good_ticks);
        if (good_ticks >= rec_lim) low_batt = 1'b0;
      end
      if (v < lvl_crit) begin
        crit_sags = count_up(crit_sags);
        if (crit_sags >= sag_lim) crit_batt = 1'b1;
      end else begin
        crit_sags = '0;
        if (good_ticks >= rec_lim) crit_batt = 1'b0;
      end
    end else begin
      // A reading at or below the floor flags low battery without counting.
      low_batt = 1'b1;
    end
  endfunction

  // Full tick update; returns the word the block must send for this tick.
  function automatic pulse_word_t predict_tick(input tick_t t);
    pulse_word_t w;
    logic [TimeW-1:0] silence;
    w.throttle = stick_pulse(t.throttle);
    w.roll     = stick_pulse(t.roll);
    w.pitch    = PitchMirror[ChanW-1:0] - stick_pulse(t.pitch);
    w.yaw      = stick_pulse(t.yaw);
    w.aux      = t.aux ? PulseMax : PulseMin;
    if (!t.arm) stop_held = 1'b0;
    // Forced stop uses the critical flag left by the previous tick.
    if (crit_batt || stop_held) begin
      stop_held    = 1'b1;
      w.throttle   = PulseMin;
      w.arm_cmd    = 1'b0;
      w.disarm_cmd = 1'b1;
      w.arm_lamp   = 1'b0;
    end else begin
      w.arm_cmd    = t.arm;
      w.disarm_cmd = !t.arm;
      w.arm_lamp   = t.arm;
    end
    if (t.link_ok) begin
      last_link_ms = t.now;
      link_down    = 1'b0;
      if (t.telem) apply_reading(t.volt);
    end
    silence = t.now - last_link_ms;
    if (silence > {16'd0, fs_ms}) begin
      link_down  = 1'b1;
      low_batt   = 1'b0;
      crit_batt  = 1'b0;
      low_sags   = '0;
      crit_sags  = '0;
      good_ticks = '0;
    end
    w.buzzer   = crit_batt && t.arm && !link_down && ((t.now % BuzzPeriod) < BuzzOn);
    w.low_lamp = low_batt;
    w.failsafe = link_down;
    return w;
  endfunction

  function automatic tick_t mk_tick(input int unsigned thr, input int unsigned roll,
                                    input int unsigned pitch, input int unsigned yaw,
                                    input bit arm, input bit aux, input bit link_ok,
                                    input bit telem, input int unsigned volt,
                                    input logic [TimeW-1:0] now);
    tick_t t;
    t.throttle = thr[StickW-1:0];
    t.roll     = roll[StickW-1:0];
    t.pitch    = pitch[StickW-1:0];
    t.yaw      = yaw[StickW-1:0];
    t.arm      = arm;
    t.aux      = aux;
    t.link_ok  = link_ok;
    t.telem    = telem;
    t.volt     = volt[LevelW-1:0];
    t.now      = now;
    return t;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result checker: every accepted output word against the oldest prediction.
  always @(posedge clk_i) begin : check_words
    pulse_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: output word with nothing expected, throttle %0d", $time,
                 throttle_out_o);
      end else begin
        want = pending_words.pop_front();
        check_field("throttle_out", want.throttle, throttle_out_o);
        check_field("roll_out", want.roll, roll_out_o);
        check_field("pitch_out", want.pitch, pitch_out_o);
        check_field("yaw_out", want.yaw, yaw_out_o);
        check_field("aux_out", want.aux, aux_out_o);
        check_field("arm_cmd", want.arm_cmd, arm_cmd_o);
        check_field("disarm_cmd", want.disarm_cmd, disarm_cmd_o);
        check_field("arm_lamp", want.arm_lamp, arm_lamp_o);
        check_field("low_batt_lamp", want.low_lamp, low_batt_lamp_o);
        check_field("buzzer_on", want.buzzer, buzzer_on_o);
        check_field("failsafe_flag", want.failsafe, failsafe_flag_o);
      end
    end
  end

  // Receiver pacing: ready runs broken by stalls, with some long open stretches.
  initial begin : sink_pacing
    int run;
    int hold;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(negedge clk_i) out_ready_i <= 1'b1;
      hold = pick_gap();
      repeat (hold) @(negedge clk_i) out_ready_i <= 1'b0;
    end
  end

  // Send one tick word, predict its result on acceptance, then idle at random.
  task automatic send_tick(input tick_t t);
    int gap;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    throttle_raw_i <= t.throttle;
    roll_raw_i     <= t.roll;
    pitch_raw_i    <= t.pitch;
    yaw_raw_i      <= t.yaw;
    arm_switch_i   <= t.arm;
    aux_switch_i   <= t.aux;
    link_ok_i      <= t.link_ok;
    telem_valid_i  <= t.telem;
    voltage_raw_i  <= t.volt;
    now_ms_i       <= t.now;
    do @(posedge clk_i); while (!in_ready_o);
    pending_words.push_back(predict_tick(t));
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic wait_results_done();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Register write; bits above the field width carry random data.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    logic [CfgDataW-1:0] keep;
    logic [CfgDataW-1:0] data;
    unique case (idx)
      REG_FLOOR_LEVEL, REG_LOW_LEVEL, REG_CRITICAL_LEVEL: keep = 16'h0FFF;
      REG_SAG_LIMIT, REG_RECOVERY_LIMIT:                  keep = 16'h00FF;
      REG_FAILSAFE_MS:                                    keep = 16'hFFFF;
      default:                                            keep = 16'h0000;
    endcase
    data = (value[CfgDataW-1:0] & keep) | (CfgDataW'($urandom) & ~keep);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned fl, input int unsigned lo,
                          input int unsigned cr, input int unsigned sg,
                          input int unsigned rc, input int unsigned fs);
    write_reg(REG_FLOOR_LEVEL, fl);
    write_reg(REG_LOW_LEVEL, lo);
    write_reg(REG_CRITICAL_LEVEL, cr);
    write_reg(REG_SAG_LIMIT, sg);
    write_reg(REG_RECOVERY_LIMIT, rc);
    write_reg(REG_FAILSAFE_MS, fs);
  endtask

  // Battery reading inside the band of the current sag episode.
  function automatic logic [LevelW-1:0] pick_volt(input batt_mode_e m);
    int lo;
    int hi;
    logic [LevelW-1:0] v;
    unique case (m)
      BATT_GOOD: begin
        lo = (lvl_low > lvl_crit) ? int'(lvl_low) : int'(lvl_crit);
        hi = StickFull;
      end
      BATT_LOW: begin
        lo = int'(lvl_floor) + 1;
        hi = int'(lvl_low) - 1;
      end
      BATT_CRIT: begin
        lo = int'(lvl_floor) + 1;
        hi = int'(lvl_crit) - 1;
      end
      BATT_FLOOR: begin
        lo = 0;
        hi = int'(lvl_floor);
      end
      default: begin
        lo = 0;
        hi = StickFull;
      end
    endcase
    if (lo > hi) begin
      lo = 0;
      hi = StickFull;
    end
    v = LevelW'($urandom_range(hi, lo));
    return v;
  endfunction

  // Well-formed 100 Hz tick streams with link outages and sag episodes, plus noise.
  task automatic send_traffic(input int count);
    tick_t t;
    int r;
    int step;
    repeat (count) begin
      t = tick_t'({$urandom, $urandom, $urandom});
      if (!steady_link && $urandom_range(0, 99) < 4) begin
        // Noise word: every field random, the timestamp included.
        sim_now = t.now;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) step = 10;
        else if (r < 95) step = $urandom_range(0, 30);
        else step = $urandom_range(0, 2 * int'(fs_ms) + 20);
        sim_now = sim_now + step;
        if (outage_left > 0) begin
          outage_left--;
          t.link_ok = 1'b0;
        end else begin
          if (!steady_link && $urandom_range(0, 99) < 3) outage_left = $urandom_range(1, 80);
          t.link_ok = 1'b1;
        end
        if (t.link_ok) t.telem = ($urandom_range(0, 9) != 0);
        if (batt_left == 0) begin
          batt_mode = batt_mode_e'($urandom_range(0, 4));
          batt_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40)
                                                 : $urandom_range(100, 400);
        end
        batt_left--;
        t.volt = pick_volt(batt_mode);
        if ($urandom_range(0, 99) < 3) arm_state = !arm_state;
        t.arm = arm_state;
        t.now = sim_now;
      end
      send_tick(t);
    end
  endtask

  // Stick extremes, both switch positions and the pitch mirror.
  task automatic test_channel_scaling();
    send_tick(mk_tick(0, 4095, 0, 4095, 1, 0, 1, 1, 3000, 32'd10));
    send_tick(mk_tick(4095, 0, 4095, 0, 0, 1, 1, 1, 3000, 32'd20));
    send_tick(mk_tick(1, 4094, 2047, 2048, 1, 1, 1, 0, 0, 32'd30));
    send_tick(mk_tick(2048, 2047, 1, 4094, 0, 0, 1, 1, 4095, 32'd40));
    send_tick(mk_tick(4094, 1, 4095, 0, 1, 0, 1, 1, 2400, 32'd50));
  endtask

  // Link timeout at its boundary, telemetry without link and timestamp wrap.
  task automatic test_link_timeout();
    send_tick(mk_tick(2000, 2000, 2000, 2000, 1, 0, 0, 1, 0, 32'd60));
    send_tick(mk_tick(2000, 2000, 2000, 2000, 1, 0, 0, 0, 0, 32'd550));
    send_tick(mk_tick(2000, 2000, 2000, 2000, 1, 0, 0, 0, 0, 32'd551));
    send_tick(mk_tick(2000, 2000, 2000, 2000, 1, 0, 1, 1, 3000, 32'd560));
    send_tick(mk_tick(100, 200, 300, 400, 1, 1, 1, 1, 3000, 32'hFFFF_FF00));
    send_tick(mk_tick(100, 200, 300, 400, 1, 1, 0, 0, 3000, 32'h0000_00F0));
    send_tick(mk_tick(100, 200, 300, 400, 1, 1, 0, 0, 3000, 32'h0000_0100));
    send_tick(mk_tick(100, 200, 300, 400, 1, 1, 1, 1, 3000, 32'h0000_0110));
  endtask

  // Floor reading, low and critical sag, forced stop, latch release, zero limits.
  task automatic test_battery_guard();
    wait_results_done();
    write_reg(REG_SAG_LIMIT, 1);
    write_reg(REG_RECOVERY_LIMIT, 1);
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 2057, 32'd1000));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 3000, 32'd1010));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 2300, 32'd1020));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 2200, 32'd1030));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 2200, 32'd1300));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 3000, 32'd1310));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 3000, 32'd1320));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 0, 0, 1, 1, 3000, 32'd1330));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 3000, 32'd1340));
    wait_results_done();
    write_reg(REG_SAG_LIMIT, 0);
    write_reg(REG_RECOVERY_LIMIT, 0);
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 3000, 32'd1350));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 2300, 32'd1360));
    send_tick(mk_tick(3000, 2000, 2000, 2000, 1, 0, 1, 1, 2100, 32'd1370));
  endtask

  // Random traffic over default, extreme, saturating and random settings.
  task automatic test_random_traffic();
    int fl;
    int cr;
    int lo;
    wait_results_done();
    set_regs(FloorLevelRst, LowLevelRst, CriticalLevelRst, SagLimitRst,
             RecoveryLimitRst, FailsafeMsRst);
    send_traffic(75);
    // Let the block run completely dry mid-stream.
    wait_results_done();
    send_traffic(75);
    wait_results_done();
    set_regs(0, 4095, 4095, 0, 0, 1);
    send_traffic(100);
    wait_results_done();
    set_regs(4095, 0, 0, 255, 255, 65535);
    send_traffic(100);
    // Long sag with a solid link drives the counters into saturation.
    wait_results_done();
    set_regs(FloorLevelRst, LowLevelRst, CriticalLevelRst, 255, 255, FailsafeMsRst);
    steady_link = 1'b1;
    outage_left = 0;
    batt_mode   = BATT_CRIT;
    batt_left   = 320;
    send_traffic(350);
    steady_link = 1'b0;
    for (int k = 0; k < 3; k++) begin
      wait_results_done();
      if (k == 2) begin
        set_regs($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 65535));
      end else begin
        fl = $urandom_range(1500, 2300);
        cr = $urandom_range(fl, 2800);
        lo = $urandom_range(cr, 3100);
        set_regs(fl, lo, cr, $urandom_range(1, 20), $urandom_range(1, 20),
                 $urandom_range(30, 800));
      end
      write_reg(RegUnusedLo, $urandom);
      write_reg(RegUnusedHi, $urandom);
      no_gaps = (k == 1);
      send_traffic(120);
    end
    no_gaps = 1'b0;
  endtask

  initial begin : run_tests
    int guard;
    clear_predictor();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_channel_scaling();
    test_link_timeout();
    test_battery_guard();
    test_random_traffic();
    // Drain with a bound, then allow for the pipeline depth.
    @(negedge clk_i) in_valid_i <= 1'b0;
    guard = 0;
    while (pending_words.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
    end
    if (errors == 0) begin
      $display("rc_transmitter_battery_failsafe_unit regression: pass");
    end else begin
      $display("rc_transmitter_battery_failsafe_unit regression: fail");
    end
    $finish;
  end

endmodule
